@@ hw/rtl/pzc_pkg.sv @@
// Shared constants for the zero-calibrated pressure filter.
package pzc_pkg;

  localparam int OUT_W = 21;
  localparam int CFG_W = 16;
  localparam int Q_FRAC = 16;
  localparam int SAMPLE_FRAC = 8;

  localparam logic [CFG_W-1:0] GAIN_RESET = 16'd19805;
  localparam logic [CFG_W-1:0] ALPHA_RESET = 16'd9830;
  localparam logic [Q_FRAC-1:0] ROUND_HALF = 16'h8000;
  localparam int ZERO_RESET = 106314;
  localparam int ZERO_MIN_W = 17;

  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

endpackage

@@ hw/rtl/pzc_mul_q16.sv @@
// Sign-magnitude multiply by a Q0.16 weight with round to nearest, ties away from zero.
module pzc_mul_q16
  import pzc_pkg::*;
#(
  parameter int A_W = 22
) (
  input  logic [A_W-1:0]    a_mag,
  input  logic              a_neg,
  input  logic [CFG_W-1:0]  weight,
  output logic signed [A_W:0] res
);

  logic [A_W+Q_FRAC-1:0] prod;
  logic [A_W-1:0]        rnd;

  assign prod = (A_W+Q_FRAC)'(a_mag) * (A_W+Q_FRAC)'(weight)
              + (A_W+Q_FRAC)'(ROUND_HALF);
  assign rnd = prod[A_W+Q_FRAC-1:Q_FRAC];
  assign res = a_neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

endmodule

@@ hw/rtl/pressure_zero_cal_ema_top.sv @@
// Top level of the zero-calibrated pressure filter with exponential smoothing.
// Calibration items are accepted back to back; the last one passes through ST_DIV and
// ST_DIVH, where a reciprocal multiply forms the zero reference. Measurement steps:
// accept, gain product on the shared Q0.16 multiplier, subtract, smoothing product;
// the smoothing step registers the result and waits while the output is stalled.
// Synchronous active-low reset clears calibration and the filter; resets registers.
module pressure_zero_cal_ema_top
  import pzc_pkg::*;
#(
  parameter int CALIB_SAMPLES = 40,
  parameter int ADC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ADC_BITS-1:0]    in_adc_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OUT_W-1:0] out_smoothed_pressure,
  output logic signed [OUT_W-1:0] out_instant_pressure,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W = ADC_BITS + CW;
  localparam int NUM_W = SUM_W + SAMPLE_FRAC;
  localparam int ZW = (ADC_BITS + SAMPLE_FRAC > ZERO_MIN_W) ? ADC_BITS + SAMPLE_FRAC
                                                             : ZERO_MIN_W;
  localparam int PW = (ZW + 1 > OUT_W) ? ZW + 1 : OUT_W;
  localparam int RS = NUM_W + $clog2(CALIB_SAMPLES);
  localparam int RW = NUM_W + 1;
  localparam int CH = (NUM_W + 1) / 2;
  localparam int PP_W = CH + RW;
  localparam int ACC_W = NUM_W + RW;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RS) + 64'(CALIB_SAMPLES) - 64'd1)
                                        / 64'(CALIB_SAMPLES));
  localparam logic [CW-1:0] CAL_LAST = CW'(CALIB_SAMPLES - 1);
  localparam logic [CW-1:0] CAL_END = CW'(CALIB_SAMPLES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV = 3'd1;
  localparam logic [2:0] ST_MULP = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_MULE = 3'd4;
  localparam logic [2:0] ST_DIVH = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [CFG_W-1:0]        gain_r, alpha_r;
  logic [CW-1:0]           cal_cnt_r, cal_cnt_nxt;
  logic [SUM_W-1:0]        cal_sum_r, cal_sum_nxt;
  logic [ZW-1:0]           zero_r, zero_nxt;
  logic signed [PW-1:0]    ema_r, ema_nxt;
  logic signed [PW-1:0]    p_r, p_nxt;
  logic [PW:0]             op_mag_r, op_mag_nxt;
  logic                    op_neg_r, op_neg_nxt;
  logic [NUM_W-1:0]        div_num_r, div_num_nxt;
  logic [ACC_W-1:0]        div_acc_r, div_acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_filt_r, out_filt_nxt;
  logic signed [OUT_W-1:0] out_inst_r, out_inst_nxt;

  logic                    in_fire, out_free, cfg_wr;
  logic [SUM_W-1:0]        sum_add;
  logic signed [PW:0]      diff_in, diff_ema;
  logic [CH-1:0]           div_chunk;
  logic [PP_W-1:0]         div_pp;
  logic [ACC_W-1:0]        div_sum;
  logic [CFG_W-1:0]        mul_w;
  logic signed [PW+1:0]    mul_res;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_smoothed_pressure = out_filt_r;
  assign out_instant_pressure = out_inst_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ALPHA) ? {16'd0, alpha_r} : {16'd0, gain_r};

  assign sum_add = cal_sum_r + SUM_W'(in_adc_sample);
  assign diff_in = $signed((PW+1)'(zero_r))
                 - $signed((PW+1)'({in_adc_sample, {SAMPLE_FRAC{1'b0}}}));
  assign diff_ema = {p_r[PW-1], p_r} - {ema_r[PW-1], ema_r};
  assign div_chunk = (state_r == ST_DIVH) ? CH'(div_num_r[NUM_W-1:CH])
                                          : div_num_r[CH-1:0];
  assign div_pp = PP_W'(div_chunk) * PP_W'(RECIP);
  assign div_sum = div_acc_r + (ACC_W'(div_pp) << CH);
  assign mul_w = (state_r == ST_MULP) ? gain_r : alpha_r;

  pzc_mul_q16 #(
    .A_W(PW + 1)
  ) u_mul (
    .a_mag (op_mag_r),
    .a_neg (op_neg_r),
    .weight(mul_w),
    .res   (mul_res)
  );

  always_comb begin
    state_nxt = state_r;
    cal_cnt_nxt = cal_cnt_r;
    cal_sum_nxt = cal_sum_r;
    zero_nxt = zero_r;
    ema_nxt = ema_r;
    p_nxt = p_r;
    op_mag_nxt = op_mag_r;
    op_neg_nxt = op_neg_r;
    div_num_nxt = div_num_r;
    div_acc_nxt = div_acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_filt_nxt = out_filt_r;
    out_inst_nxt = out_inst_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cal_cnt_r != CAL_END) begin
            cal_sum_nxt = sum_add;
            cal_cnt_nxt = cal_cnt_r + 1'b1;
            if (cal_cnt_r == CAL_LAST) begin
              div_num_nxt = {sum_add, {SAMPLE_FRAC{1'b0}}} + NUM_W'(CALIB_SAMPLES / 2);
              state_nxt = ST_DIV;
            end
          end else begin
            op_neg_nxt = diff_in[PW];
            op_mag_nxt = diff_in[PW] ? (PW+1)'(-diff_in) : (PW+1)'(diff_in);
            state_nxt = ST_MULP;
          end
        end
      end
      ST_DIV: begin
        div_acc_nxt = ACC_W'(div_pp);
        state_nxt = ST_DIVH;
      end
      ST_DIVH: begin
        zero_nxt = div_sum[RS +: ZW];
        state_nxt = ST_IDLE;
      end
      ST_MULP: begin
        p_nxt = mul_res[PW-1:0];
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        op_neg_nxt = diff_ema[PW];
        op_mag_nxt = diff_ema[PW] ? (PW+1)'(-diff_ema) : (PW+1)'(diff_ema);
        state_nxt = ST_MULE;
      end
      ST_MULE: begin
        if (out_free) begin
          ema_nxt = ema_r + mul_res[PW-1:0];
          out_valid_nxt = 1'b1;
          out_filt_nxt = ema_nxt[OUT_W-1:0];
          out_inst_nxt = p_r[OUT_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gain_r <= GAIN_RESET;
      alpha_r <= ALPHA_RESET;
      cal_cnt_r <= '0;
      cal_sum_r <= '0;
      zero_r <= ZW'(ZERO_RESET);
      ema_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cal_cnt_r <= cal_cnt_nxt;
      cal_sum_r <= cal_sum_nxt;
      zero_r <= zero_nxt;
      ema_r <= ema_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_ALPHA) begin
          alpha_r <= pwdata[CFG_W-1:0];
        end else begin
          gain_r <= pwdata[CFG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    op_mag_r <= op_mag_nxt;
    op_neg_r <= op_neg_nxt;
    div_num_r <= div_num_nxt;
    div_acc_r <= div_acc_nxt;
    out_filt_r <= out_filt_nxt;
    out_inst_r <= out_inst_nxt;
  end

  a_result_from_mule: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_MULE)
    else $error("Result appeared without a smoothing step.");

  a_no_measure_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (cal_cnt_r != CAL_END) |-> (state_r != ST_MULP && state_r != ST_MULE))
    else $error("Measurement started before calibration finished.");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIVH))
    else $error("Reciprocal multiply left to an unexpected state.");

endmodule

@@ tb/tb_pressure_zero_cal_ema_top.sv @@
// Self-checking testbench for the zero-calibrated pressure filter with exponential smoothing.
module tb_pressure_zero_cal_ema_top;
  import pzc_pkg::*;

  localparam int CALIB_N = 40;
  localparam int ADC_W = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic signed [OUT_W-1:0] filtered;
    logic signed [OUT_W-1:0] instant;
  } pressure_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADC_W-1:0] in_adc_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_smoothed_pressure;
  logic signed [OUT_W-1:0] out_instant_pressure;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [ADC_W-1:0] samples_to_send[$];
  pressure_pair_t pressure_due[$];
  pressure_pair_t due_now;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  logic [CFG_W-1:0] gain_cfg = GAIN_RESET;
  logic [CFG_W-1:0] alpha_cfg = ALPHA_RESET;
  int cal_count = 0;
  longint cal_sum = 0;
  longint zero_ref = ZERO_RESET;
  longint ema = 0;

  pressure_zero_cal_ema_top #(
    .CALIB_SAMPLES(CALIB_N),
    .ADC_BITS(ADC_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_adc_sample(in_adc_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_smoothed_pressure(out_smoothed_pressure),
    .out_instant_pressure(out_instant_pressure),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Signed value times a Q0.16 weight, rounded to nearest with ties away from zero.
  function automatic longint scale_q16(input longint a, input logic [CFG_W-1:0] w);
    longint mag;
    longint wl;
    longint r;
    wl = w;
    mag = (a < 0) ? -a : a;
    r = (mag * wl + longint'(ROUND_HALF)) >>> Q_FRAC;
    return (a < 0) ? -r : r;
  endfunction

  task automatic predict_pressure(input logic [ADC_W-1:0] s);
    longint diff;
    longint p;
    pressure_pair_t r;
    if (cal_count < CALIB_N) begin
      cal_sum += s;
      cal_count++;
      if (cal_count == CALIB_N) begin
        zero_ref = (cal_sum * 256 + CALIB_N / 2) / CALIB_N;
      end
    end else begin
      diff = zero_ref - longint'(s) * 256;
      p = scale_q16(diff, gain_cfg);
      ema = ema + scale_q16(p - ema, alpha_cfg);
      r.filtered = ema[OUT_W-1:0];
      r.instant = p[OUT_W-1:0];
      pressure_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pressure(in_adc_sample);
      end
      if (!(in_valid && in_stall)) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_adc_sample <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pressure_due.size() == 0) begin
        report_mismatch("result item with no sample pending");
      end else begin
        due_now = pressure_due.pop_front();
        if (out_smoothed_pressure !== due_now.filtered) begin
          report_mismatch($sformatf("smoothed_pressure got %0d want %0d",
                                    out_smoothed_pressure, due_now.filtered));
        end
        if (out_instant_pressure !== due_now.instant) begin
          report_mismatch($sformatf("instant_pressure got %0d want %0d",
                                    out_instant_pressure, due_now.instant));
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    logic [15:0] upper;
    upper = 16'($urandom_range(65535));
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx));
    pwdata <= {upper, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_GAIN) begin
      gain_cfg = val;
    end else begin
      alpha_cfg = val;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || pressure_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [ADC_W-1:0] near_zero_sample();
    int c;
    c = int'(zero_ref >>> SAMPLE_FRAC) + $urandom_range(128) - 64;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return ADC_W'(c);
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1) == 1) begin
        samples_to_send.push_back(ADC_W'($urandom_range(4095)));
      end else begin
        samples_to_send.push_back(near_zero_sample());
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] alpha,
                           input int idle, input int stall, input int n);
    write_reg(REG_GAIN, gain);
    write_reg(REG_ALPHA, alpha);
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct = stall;
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Calibration runs on register reset values with light idling on both sides.
    send_idle_pct = 22;
    stall_pct = 22;
    samples_to_send.push_back(ADC_W'(0));
    samples_to_send.push_back(ADC_W'(4095));
    for (int i = 2; i < CALIB_N; i++) begin
      samples_to_send.push_back(ADC_W'($urandom_range(4095)));
    end
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 0;
    samples_to_send.push_back(ADC_W'(0));
    samples_to_send.push_back(ADC_W'(4095));
    samples_to_send.push_back(ADC_W'(4095));
    samples_to_send.push_back(ADC_W'(0));
    samples_to_send.push_back(ADC_W'(12'h555));
    samples_to_send.push_back(ADC_W'(12'hAAA));
    samples_to_send.push_back(ADC_W'(zero_ref >>> SAMPLE_FRAC));
    samples_to_send.push_back(ADC_W'((zero_ref >>> SAMPLE_FRAC) + 1));
    samples_to_send.push_back(ADC_W'((zero_ref >>> SAMPLE_FRAC) - 1));
    samples_to_send.push_back(ADC_W'(2048));
    samples_to_send.push_back(ADC_W'(1));
    samples_to_send.push_back(ADC_W'(4094));
    wait_drained();

    run_phase(16'hFFFF, 16'hFFFF, 0, 0, 60);
    run_phase(16'h0000, 16'h0000, 81, 0, 40);
    // Half weights make exact rounding ties on odd differences.
    run_phase(16'h8000, 16'h8000, 0, 81, 80);
    run_phase(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)), 22, 22, 80);
    run_phase(GAIN_RESET, ALPHA_RESET, 0, 0, 80);
    run_phase(16'hFFFF, 16'h0001, 81, 0, 60);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
